FILE: rtl/cdtt_pkg.sv
package cdtt_pkg;

    // Widths fixed by the item format.
    localparam int unsigned TS_W    = 64;
    localparam int unsigned CLK_W   = 3;
    localparam int unsigned OP_W    = 2;

    // Default sizing.
    localparam int unsigned DEF_CLOCKS  = 8;
    localparam int unsigned DEF_ENTRIES = 16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_CONV    = 2'd1;
    localparam logic [OP_W-1:0] OP_CONV_PR = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the item and look up the pair fill
        logic step;       // evaluate returned anchor, advance scan index
        logic mark;       // keep the insert position, move index to fill
        logic shift_rd;   // read entry (idx-1) for a move up
        logic shift_wr;   // write moved entry to idx, decrement idx
        logic ins_wr;     // write new anchor at idx, bump fill
        logic done;       // drive the result strobe
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_add;     // item is an add
        logic no_table;   // clock out of range or unused op
        logic empty;      // pair holds no anchor
        logic scan_end;   // scan stopped or scan index reached fill
        logic match;      // add found an equal anchor
        logic full;       // pair table is full
        logic shift_end;  // insert position reached
    } t_sts;

endpackage

FILE: rtl/cdtt_ram.sv
module cdtt_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cdtt_dp.sv
module cdtt_dp #(
    parameter int unsigned CLOCKS  = cdtt_pkg::DEF_CLOCKS,
    parameter int unsigned ENTRIES = cdtt_pkg::DEF_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cdtt_pkg::t_cmd                i_cmd,
    output cdtt_pkg::t_sts                o_sts,
    input  logic [cdtt_pkg::CLK_W-1:0]    i_primary,
    input  logic [cdtt_pkg::OP_W-1:0]     i_op,
    input  logic [cdtt_pkg::CLK_W-1:0]    i_src_clock,
    input  logic [cdtt_pkg::CLK_W-1:0]    i_dst_clock,
    input  logic [cdtt_pkg::TS_W-1:0]     i_src_ts,
    input  logic [cdtt_pkg::TS_W-1:0]     i_dst_ts,
    output logic [cdtt_pkg::TS_W-1:0]     o_out_ts,
    output logic                          o_pair_known,
    output logic                          o_dropped
);

    localparam int unsigned PAIRS   = CLOCKS * CLOCKS;
    localparam int unsigned PAIR_W  = $clog2(PAIRS);
    localparam int unsigned FILL_W  = $clog2(ENTRIES + 1);
    localparam int unsigned DEPTH   = PAIRS * ENTRIES;
    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam int unsigned TS_W    = cdtt_pkg::TS_W;
    localparam int unsigned CLK_W_L = cdtt_pkg::CLK_W;

    // Item registers.
    logic [cdtt_pkg::OP_W-1:0] r_op;
    logic [TS_W-1:0]           r_sts;
    logic [TS_W-1:0]           r_dts;
    logic [PAIR_W-1:0]         r_pair;
    logic                      r_valid_pair;
    logic                      r_src_is_pr;
    logic [FILL_W-1:0]         r_n;
    logic [FILL_W-1:0]         r_idx;
    logic [FILL_W-1:0]         r_pos;
    logic                      r_stop;
    logic                      r_match;
    logic [TS_W-1:0]           r_out_ts;
    logic                      r_known;
    logic                      r_drop;
    logic                      r_strobe;
    logic                      r_fetch;
    logic                      r_fvalid [PAIRS];

    logic [CLK_W_L-1:0] w_dst;
    logic [PAIR_W-1:0]  w_pair;
    logic [ADDR_W-1:0]  w_raddr;
    logic [ADDR_W-1:0]  w_waddr;
    logic [TS_W-1:0]    w_time_rd;
    logic [TS_W-1:0]    w_off_rd;
    logic [TS_W-1:0]    w_time_wd;
    logic [TS_W-1:0]    w_off_wd;
    logic               w_we;
    logic [FILL_W-1:0]  w_ridx;
    logic               w_clk_ok;
    logic               w_op_ok;
    logic [FILL_W-1:0]  w_fill_rd;
    logic [FILL_W-1:0]  w_fill_wd;
    logic [FILL_W-1:0]  w_n;

    // Destination clock for the item and the flattened pair number.
    assign w_dst    = (i_op == cdtt_pkg::OP_CONV_PR) ? i_primary : i_dst_clock;
    assign w_clk_ok = (32'(i_src_clock) < CLOCKS) && (32'(w_dst) < CLOCKS);
    assign w_pair   = PAIR_W'(32'(i_src_clock) * CLOCKS + 32'(w_dst));
    assign w_op_ok  = (r_op == cdtt_pkg::OP_ADD) || (r_op == cdtt_pkg::OP_CONV) ||
                      (r_op == cdtt_pkg::OP_CONV_PR);

    // Memory addresses: scan/move reads at idx or idx-1, writes at idx.
    assign w_ridx  = i_cmd.shift_rd ? (r_idx - FILL_W'(1)) : r_idx;
    assign w_raddr = ADDR_W'(32'(r_pair) * ENTRIES + 32'(w_ridx));
    assign w_waddr = ADDR_W'(32'(r_pair) * ENTRIES + 32'(r_idx));
    assign w_we    = i_cmd.shift_wr || i_cmd.ins_wr;
    assign w_time_wd = i_cmd.ins_wr ? r_sts : w_time_rd;
    assign w_off_wd  = i_cmd.ins_wr ? (r_dts - r_sts) : w_off_rd;

    cdtt_ram #(.WIDTH(TS_W), .DEPTH(DEPTH)) u_time (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_time_wd),
        .i_raddr(w_raddr), .o_rdata(w_time_rd)
    );

    cdtt_ram #(.WIDTH(TS_W), .DEPTH(DEPTH)) u_off (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_off_wd),
        .i_raddr(w_raddr), .o_rdata(w_off_rd)
    );

    // Fill count per pair. It is read at the load edge and arrives in the cycle
    // after; a pair whose valid bit is clear has never been written and holds
    // no anchor.
    assign w_fill_wd = r_n + FILL_W'(1);
    assign w_n       = (r_valid_pair && r_fvalid[r_pair]) ? w_fill_rd : '0;

    cdtt_ram #(.WIDTH(FILL_W), .DEPTH(PAIRS)) u_fill (
        .i_clk(i_clk), .i_we(i_cmd.ins_wr), .i_waddr(r_pair), .i_wdata(w_fill_wd),
        .i_raddr(w_pair), .o_rdata(w_fill_rd)
    );

    // Item capture, scan bookkeeping and result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_fetch  <= 1'b0;
            for (int p = 0; p < PAIRS; p++) begin
                r_fvalid[p] <= 1'b0;
            end
        end else begin
            r_strobe <= i_cmd.done;
            r_fetch  <= i_cmd.load;
            if (i_cmd.ins_wr) begin
                r_fvalid[r_pair] <= 1'b1;
            end
        end
        if (i_cmd.load) begin
            r_op         <= i_op;
            r_sts        <= i_src_ts;
            r_dts        <= i_dst_ts;
            r_pair       <= w_pair;
            r_valid_pair <= w_clk_ok;
            r_src_is_pr  <= (i_src_clock == i_primary);
            r_idx        <= '0;
            r_stop       <= 1'b0;
            r_match      <= 1'b0;
        end
        if (r_fetch) begin
            r_n <= w_n;
        end
        if (i_cmd.step) begin
            if (r_op == cdtt_pkg::OP_ADD) begin
                if (w_time_rd == r_sts) begin
                    r_match <= 1'b1;
                    r_stop  <= 1'b1;
                end else if (w_time_rd > r_sts) begin
                    r_stop <= 1'b1;
                end else begin
                    r_idx <= r_idx + FILL_W'(1);
                end
            end else begin
                if (w_time_rd <= r_sts) begin
                    r_out_ts <= r_sts + w_off_rd;
                    r_idx    <= r_idx + FILL_W'(1);
                end else begin
                    r_stop <= 1'b1;
                    if (r_idx == '0) begin
                        r_out_ts <= r_sts + w_off_rd;
                    end
                end
            end
        end
        // The scan stopped at the insert position; moves start from the top.
        if (i_cmd.mark) begin
            r_pos <= r_idx;
            r_idx <= r_n;
        end
        if (i_cmd.shift_wr) begin
            r_idx <= r_idx - FILL_W'(1);
        end
        if (i_cmd.done) begin
            r_known <= r_valid_pair && (r_n != '0) && w_op_ok;
            r_drop  <= (r_op == cdtt_pkg::OP_ADD) &&
                       (!r_valid_pair || (!r_match && r_n == FILL_W'(ENTRIES)));
            if (r_op == cdtt_pkg::OP_ADD || !w_op_ok) begin
                r_out_ts <= '0;
            end else if (!r_valid_pair || r_n == '0 ||
                         (r_op == cdtt_pkg::OP_CONV_PR && r_src_is_pr)) begin
                r_out_ts <= r_sts;
            end
        end
    end

    // Status toward the controller; empty is meaningful in the cycle after load.
    assign o_sts.is_add    = (r_op == cdtt_pkg::OP_ADD);
    assign o_sts.no_table  = !r_valid_pair || !w_op_ok;
    assign o_sts.empty     = (w_n == '0);
    assign o_sts.scan_end  = r_stop || (r_idx == r_n);
    assign o_sts.match     = r_match;
    assign o_sts.full      = (r_n == FILL_W'(ENTRIES));
    assign o_sts.shift_end = (r_idx == r_pos);

    assign o_out_ts     = r_out_ts;
    assign o_pair_known = r_strobe & r_known;
    assign o_dropped    = r_strobe & r_drop;

endmodule

FILE: rtl/cdtt_ctrl.sv
module cdtt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  cdtt_pkg::t_sts i_sts,
    output cdtt_pkg::t_cmd o_cmd,
    output logic           o_busy,
    output logic           o_strobe
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_RD, S_EVAL, S_MARK, S_SHRD, S_SHWR, S_DONE
    } t_state;

    t_state r_state;
    logic   r_strobe;

    // Commands are decoded from the state and status.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.load = i_start;
            S_EVAL:  o_cmd.step = 1'b1;
            S_MARK:  o_cmd.mark = 1'b1;
            S_SHRD:  o_cmd.shift_rd = 1'b1;
            S_SHWR:  begin
                o_cmd.shift_wr = !i_sts.shift_end;
                o_cmd.ins_wr   = i_sts.shift_end;
            end
            S_DONE:  o_cmd.done = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_DONE);
            unique case (r_state)
                S_IDLE:  if (i_start) r_state <= S_CHECK;
                S_CHECK: begin
                    if (i_sts.no_table || i_sts.empty) begin
                        r_state <= (i_sts.is_add && !i_sts.no_table) ? S_MARK : S_DONE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                // Scan ends: adds continue to the move phase unless matched or full.
                S_RD:    begin
                    if (!i_sts.scan_end) begin
                        r_state <= S_EVAL;
                    end else if (i_sts.is_add && !i_sts.match && !i_sts.full) begin
                        r_state <= S_MARK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_EVAL:  r_state <= S_RD;
                S_MARK:  r_state <= S_SHRD;
                S_SHRD:  r_state <= S_SHWR;
                S_SHWR:  r_state <= i_sts.shift_end ? S_DONE : S_SHRD;
                S_DONE:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |=> !o_cmd.done) else $error("double done");
    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !$past(o_strobe)) else $error("strobe twice");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_busy) else $error("load without busy");

endmodule

FILE: rtl/clock_domain_timestamp_translator_top.sv
// An accepted add or convert whose pair table holds anchors first scans them,
// with a read and an evaluate step per anchor; an add that inserts then moves
// entries up, with a read and a write step per entry. One item at a time; busy
// drops in the result cycle, so a new item can start only once the last one is
// done. Reset (synchronous, active low) empties every pair table and sets the
// primary clock to 0. The receiver cannot stall results.
module clock_domain_timestamp_translator_top #(
    parameter int unsigned CLOCKS  = cdtt_pkg::DEF_CLOCKS,
    parameter int unsigned ENTRIES = cdtt_pkg::DEF_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic [cdtt_pkg::CLK_W-1:0] i_cfg_wdata,
    input  logic [cdtt_pkg::OP_W-1:0]  i_op,
    input  logic [cdtt_pkg::CLK_W-1:0] i_src_clock,
    input  logic [cdtt_pkg::CLK_W-1:0] i_dst_clock,
    input  logic [cdtt_pkg::TS_W-1:0]  i_src_ts,
    input  logic [cdtt_pkg::TS_W-1:0]  i_dst_ts,
    output logic                       o_valid,
    output logic [cdtt_pkg::TS_W-1:0]  o_out_ts,
    output logic                       o_pair_known,
    output logic                       o_dropped
);

    cdtt_pkg::t_cmd w_cmd;
    cdtt_pkg::t_sts w_sts;
    logic [cdtt_pkg::CLK_W-1:0] r_primary;

    // Primary clock register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primary <= '0;
        end else if (i_cfg_we) begin
            r_primary <= i_cfg_wdata;
        end
    end

    cdtt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_sts(w_sts),
        .o_cmd(w_cmd), .o_busy(busy), .o_strobe(o_valid)
    );

    cdtt_dp #(.CLOCKS(CLOCKS), .ENTRIES(ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_primary(r_primary), .i_op(i_op), .i_src_clock(i_src_clock),
        .i_dst_clock(i_dst_clock), .i_src_ts(i_src_ts), .i_dst_ts(i_dst_ts),
        .o_out_ts(o_out_ts), .o_pair_known(o_pair_known), .o_dropped(o_dropped)
    );

endmodule
